[rtl/tgql_pkg.sv]
`default_nettype none

package tgql_pkg;

  localparam int GLYPH_COUNT_DEF = 95;

  localparam int CHAR_W   = 8;
  localparam int WIDTH_W  = 8;
  localparam int EDGE_W   = 15;
  localparam int COORD_W  = 16;
  localparam int COLOR_W  = 4;
  localparam int ALPHA_W  = 5;
  localparam int GIDX_W   = 7;
  localparam int GLYPH_W  = EDGE_W + WIDTH_W;  // {left edge, width}

  localparam logic [7:0] LINE_HEIGHT_RST = 8'd8;
  localparam logic [ALPHA_W-1:0] ALPHA_OPAQUE = 5'd25;

  localparam logic [CHAR_W-1:0] CHAR_NL    = 8'h0A;
  localparam logic [CHAR_W-1:0] CHAR_FF    = 8'h0C;
  localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CHAR_TILDE = 8'h7E;
  localparam logic [CHAR_W-1:0] CHAR_0     = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_9     = 8'h39;
  localparam logic [CHAR_W-1:0] CHAR_LC_A  = 8'h61;
  localparam logic [CHAR_W-1:0] CHAR_LC_F  = 8'h66;
  localparam logic [CHAR_W-1:0] CHAR_LC_T  = 8'h74;
  localparam logic [CHAR_W-1:0] CHAR_LC_Z  = 8'h7A;
  localparam logic [CHAR_W-1:0] HEX_A_VAL  = 8'd10;

  localparam logic [2:0] VERT_LAST = 3'd5;

  typedef enum logic [2:0] {
    ESC_NONE  = 3'b001,
    ESC_ARG   = 3'b010,
    ESC_ALPHA = 3'b100
  } esc_t;

endpackage

`default_nettype wire

[rtl/tgql_ram.sv]
`default_nettype none

module tgql_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 16,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [WIDTH-1:0]  wdata,
  input  wire logic              re,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

[rtl/text_glyph_quad_layout.sv]
// A printable word passes the fetch stage, the generator and the output register,
//   then its six vertices leave one per cycle while out_ready holds.
// Throughput: the single vertex port bounds printable words; one can wait in fetch.
//   Loads, control and dropped words are taken one per cycle while fetch is free.
// Reset (rst_n low, synchronous): pen, line, color, escape, edge sum and all
//   valid flags cleared, alpha opaque, line height 8; glyph memory not cleared.
`default_nettype none

module text_glyph_quad_layout
  import tgql_pkg::*;
#(
  parameter int GLYPH_COUNT = GLYPH_COUNT_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  // config
  input  wire logic                      cfg_valid,
  output logic                           cfg_ready,
  input  wire logic [7:0]                cfg_data,
  // input words
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire logic                      in_action,
  input  wire logic [CHAR_W-1:0]         in_char_code,
  input  wire logic                      in_first_of_text,
  input  wire logic [GIDX_W-1:0]         in_glyph_index,
  input  wire logic [WIDTH_W-1:0]        in_glyph_width,
  // vertex words
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output logic signed [COORD_W-1:0]      out_vert_x,
  output logic signed [COORD_W-1:0]      out_vert_y,
  output logic        [EDGE_W-1:0]       out_tex_u,
  output logic                           out_tex_v,
  output logic        [COLOR_W-1:0]      out_color_index,
  output logic        [ALPHA_W-1:0]      out_alpha_code,
  output logic                           out_last
);

  localparam int ADDR_W = (GLYPH_COUNT > 1) ? $clog2(GLYPH_COUNT) : 1;
  localparam logic [GIDX_W:0] GC_LIM = (GIDX_W + 1)'(GLYPH_COUNT);

  // ------------------------------------------------------------------
  // Architectural state
  // ------------------------------------------------------------------
  logic [7:0]          line_height_r;
  esc_t                esc_r, esc_nxt;
  logic [COLOR_W-1:0]  color_r, color_nxt;
  logic [ALPHA_W-1:0]  alpha_r, alpha_nxt;
  logic [COORD_W-1:0]  pen_r, pen_nxt;
  logic [COORD_W-1:0]  line_r, line_nxt;
  logic [EDGE_W-1:0]   edge_sum_r, edge_sum_nxt;

  // Fetch stage: glyph read issued, waiting for memory data and a free generator.
  logic                f_vld_r, f_vld_nxt;
  logic [COLOR_W-1:0]  f_color_r;
  logic [ALPHA_W-1:0]  f_alpha_r;
  logic [COORD_W-1:0]  f_y0_r;

  // Generator stage: one quad, walked through its six vertices.
  logic                g_vld_r, g_vld_nxt;
  logic [2:0]          g_cnt_r, g_cnt_nxt;
  logic [COORD_W-1:0]  g_x0_r, g_x1_r, g_y0_r, g_y1_r;
  logic [EDGE_W-1:0]   g_ul_r, g_ur_r;
  logic [COLOR_W-1:0]  g_color_r;
  logic [ALPHA_W-1:0]  g_alpha_r;

  // Output register.
  logic                out_valid_r, out_valid_nxt;
  logic [COORD_W-1:0]  out_x_r, out_y_r;
  logic [EDGE_W-1:0]   out_u_r;
  logic                out_v_r, out_last_r;
  logic [COLOR_W-1:0]  out_color_r;
  logic [ALPHA_W-1:0]  out_alpha_r;

  // ------------------------------------------------------------------
  // Handshakes
  // ------------------------------------------------------------------
  logic f_move, g_done, out_load, text_acc, load_acc;
  logic vtx_last;

  assign out_load  = g_vld_r && (!out_valid_r || out_ready);
  assign vtx_last  = (g_cnt_r == VERT_LAST);
  assign g_done    = out_load && vtx_last;
  assign f_move    = f_vld_r && (!g_vld_r || g_done);
  // A pending fetch owns pen_r until it moves on, so hold off new words meanwhile.
  assign in_ready  = !f_vld_r || f_move;
  assign text_acc  = in_valid && in_ready && !in_action;
  assign load_acc  = in_valid && in_ready && in_action;
  assign cfg_ready = 1'b1;

  // ------------------------------------------------------------------
  // Glyph memory: {left edge, width} per slot
  // ------------------------------------------------------------------
  logic                ram_we, ram_re;
  logic [ADDR_W-1:0]   ram_waddr, ram_raddr;
  logic [GLYPH_W-1:0]  ram_wdata, ram_rdata;
  logic                load_ok;
  logic [EDGE_W-1:0]   load_left;

  assign load_ok   = ({1'b0, in_glyph_index} < GC_LIM);
  assign load_left = (in_glyph_index == '0) ? '0 : edge_sum_r;
  assign ram_we    = load_acc && load_ok;
  assign ram_waddr = in_glyph_index[ADDR_W-1:0];
  assign ram_wdata = {load_left, in_glyph_width};

  tgql_ram #(
    .WIDTH  (GLYPH_W),
    .DEPTH  (GLYPH_COUNT),
    .ADDR_W (ADDR_W)
  ) u_glyph_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  logic [WIDTH_W-1:0] rd_w;
  logic [EDGE_W-1:0]  rd_left;
  assign rd_w    = ram_rdata[WIDTH_W-1:0];
  assign rd_left = ram_rdata[GLYPH_W-1:WIDTH_W];

  // ------------------------------------------------------------------
  // Text word decode
  // ------------------------------------------------------------------
  logic [CHAR_W-1:0]  ch;
  logic [GIDX_W-1:0]  slot;
  logic               is_digit, is_hex_lc, is_letter, is_print, slot_ok;
  esc_t               esc_eff;
  logic [COORD_W-1:0] line_eff;
  logic               f_load;

  assign ch        = in_char_code;
  assign slot      = GIDX_W'(ch - CHAR_SPACE);
  assign is_digit  = (ch >= CHAR_0) && (ch <= CHAR_9);
  assign is_hex_lc = (ch >= CHAR_LC_A) && (ch <= CHAR_LC_F);
  assign is_letter = (ch >= CHAR_LC_A) && (ch <= CHAR_LC_Z);
  assign is_print  = (ch >= CHAR_SPACE) && (ch <= CHAR_TILDE);
  assign slot_ok   = ({1'b0, slot} < GC_LIM);
  assign esc_eff   = in_first_of_text ? ESC_NONE : esc_r;
  assign line_eff  = in_first_of_text ? '0 : line_r;

  assign ram_re    = f_load;
  assign ram_raddr = slot[ADDR_W-1:0];

  always_comb begin
    esc_nxt   = esc_r;
    color_nxt = color_r;
    alpha_nxt = alpha_r;
    line_nxt  = line_r;
    f_load    = 1'b0;
    // pen advances when a glyph's width comes back; a later word overrides it
    pen_nxt   = f_move ? (pen_r + COORD_W'(rd_w)) : pen_r;

    if (text_acc) begin
      if (in_first_of_text) begin
        pen_nxt   = '0;
        color_nxt = '0;
        alpha_nxt = ALPHA_OPAQUE;
      end
      line_nxt = line_eff;
      esc_nxt  = ESC_NONE;
      case (esc_eff)
        ESC_ARG: begin
          if (is_digit) begin
            color_nxt = COLOR_W'(ch - CHAR_0);
          end else if (is_hex_lc) begin
            color_nxt = COLOR_W'(ch - CHAR_LC_A + HEX_A_VAL);
          end else if (ch == CHAR_LC_T) begin
            esc_nxt = ESC_ALPHA;
          end
        end
        ESC_ALPHA: begin
          if (is_letter) begin
            alpha_nxt = ALPHA_W'(ch - CHAR_LC_A);
          end
        end
        ESC_NONE: begin
          if (ch == CHAR_NL) begin
            line_nxt = line_eff - COORD_W'(line_height_r);
            pen_nxt  = '0;
          end else if (ch == CHAR_FF) begin
            esc_nxt = ESC_ARG;
          end else if (is_print && slot_ok) begin
            f_load = 1'b1;
          end
        end
        default: begin
          esc_nxt = ESC_NONE;
        end
      endcase
    end
  end

  assign edge_sum_nxt = ram_we ? (load_left + EDGE_W'(in_glyph_width)) : edge_sum_r;

  always_comb begin
    f_vld_nxt = f_vld_r;
    if (f_move) begin
      f_vld_nxt = 1'b0;
    end
    if (f_load) begin
      f_vld_nxt = 1'b1;
    end
  end

  always_comb begin
    g_vld_nxt = g_vld_r;
    g_cnt_nxt = g_cnt_r;
    if (out_load) begin
      g_cnt_nxt = vtx_last ? '0 : g_cnt_r + 3'd1;
    end
    if (g_done) begin
      g_vld_nxt = 1'b0;
    end
    if (f_move) begin
      g_vld_nxt = 1'b1;
    end
  end

  // Vertex order: (x0,y0) (x1,y1) (x0,y1) (x0,y0) (x1,y0) (x1,y1).
  // Right column uses x1 and tex_u right; top row (y1) has tex_v 0.
  logic sel_x1, sel_y1;
  always_comb begin
    case (g_cnt_r)
      3'd0:    begin sel_x1 = 1'b0; sel_y1 = 1'b0; end
      3'd1:    begin sel_x1 = 1'b1; sel_y1 = 1'b1; end
      3'd2:    begin sel_x1 = 1'b0; sel_y1 = 1'b1; end
      3'd3:    begin sel_x1 = 1'b0; sel_y1 = 1'b0; end
      3'd4:    begin sel_x1 = 1'b1; sel_y1 = 1'b0; end
      3'd5:    begin sel_x1 = 1'b1; sel_y1 = 1'b1; end
      default: begin sel_x1 = 1'b0; sel_y1 = 1'b0; end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // ------------------------------------------------------------------
  // Registers
  // ------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_height_r <= LINE_HEIGHT_RST;
      esc_r         <= ESC_NONE;
      color_r       <= '0;
      alpha_r       <= ALPHA_OPAQUE;
      pen_r         <= '0;
      line_r        <= '0;
      edge_sum_r    <= '0;
      f_vld_r       <= 1'b0;
      g_vld_r       <= 1'b0;
      g_cnt_r       <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        line_height_r <= cfg_data;
      end
      esc_r       <= esc_nxt;
      color_r     <= color_nxt;
      alpha_r     <= alpha_nxt;
      pen_r       <= pen_nxt;
      line_r      <= line_nxt;
      edge_sum_r  <= edge_sum_nxt;
      f_vld_r     <= f_vld_nxt;
      g_vld_r     <= g_vld_nxt;
      g_cnt_r     <= g_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers, no reset.
  always_ff @(posedge clk) begin
    if (f_load) begin
      f_color_r <= color_nxt;
      f_alpha_r <= alpha_nxt;
      f_y0_r    <= line_nxt;
    end
    if (f_move) begin
      g_x0_r    <= pen_r;
      g_x1_r    <= pen_r + COORD_W'(rd_w);
      g_y0_r    <= f_y0_r;
      g_y1_r    <= f_y0_r + COORD_W'(line_height_r);
      g_ul_r    <= rd_left;
      g_ur_r    <= rd_left + EDGE_W'(rd_w);
      g_color_r <= f_color_r;
      g_alpha_r <= f_alpha_r;
    end
    if (out_load) begin
      out_x_r     <= sel_x1 ? g_x1_r : g_x0_r;
      out_y_r     <= sel_y1 ? g_y1_r : g_y0_r;
      out_u_r     <= sel_x1 ? g_ur_r : g_ul_r;
      out_v_r     <= !sel_y1;
      out_color_r <= g_color_r;
      out_alpha_r <= g_alpha_r;
      out_last_r  <= vtx_last;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_vert_x      = out_x_r;
  assign out_vert_y      = out_y_r;
  assign out_tex_u       = out_u_r;
  assign out_tex_v       = out_v_r;
  assign out_color_index = out_color_r;
  assign out_alpha_code  = out_alpha_r;
  assign out_last        = out_last_r;

endmodule

`default_nettype wire

[rtl/tgql_checker.sv]
`default_nettype none

module tgql_checker
  import tgql_pkg::*;
(
  input wire logic                 clk,
  input wire logic                 rst_n,
  input wire logic                 out_valid,
  input wire logic                 out_ready,
  input wire logic [COORD_W-1:0]   out_vert_x,
  input wire logic [COORD_W-1:0]   out_vert_y,
  input wire logic [EDGE_W-1:0]    out_tex_u,
  input wire logic                 out_tex_v,
  input wire logic [COLOR_W-1:0]   out_color_index,
  input wire logic [ALPHA_W-1:0]   out_alpha_code,
  input wire logic                 out_last
);

  logic               seen_r, prev_last_r;
  logic [COLOR_W-1:0] prev_color_r;
  logic [ALPHA_W-1:0] prev_alpha_r;
  logic               out_acc;

  assign out_acc = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r       <= 1'b0;
      prev_last_r  <= 1'b1;
      prev_color_r <= '0;
      prev_alpha_r <= '0;
    end else if (out_acc) begin
      seen_r       <= 1'b1;
      prev_last_r  <= out_last;
      prev_color_r <= out_color_index;
      prev_alpha_r <= out_alpha_code;
    end
  end

  // stalled word holds its position, tex_u and last flag
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_vert_x) && $stable(out_vert_y)
      && $stable(out_tex_u) && $stable(out_last))
    else $error("vertex word changed while stalled");

  // closing vertex of a quad is on the top row
  a_last_top: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |-> !out_tex_v)
    else $error("last vertex not on top row");

  a_alpha_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_alpha_code <= ALPHA_OPAQUE)
    else $error("alpha code out of range");

  // color and alpha constant within one quad
  a_quad_attr: assert property (@(posedge clk) disable iff (!rst_n)
    out_acc && seen_r && !prev_last_r |->
      out_color_index == prev_color_r && out_alpha_code == prev_alpha_r)
    else $error("color or alpha changed inside a quad");

endmodule

bind text_glyph_quad_layout tgql_checker u_tgql_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_vert_x      (out_vert_x),
  .out_vert_y      (out_vert_y),
  .out_tex_u       (out_tex_u),
  .out_tex_v       (out_tex_v),
  .out_color_index (out_color_index),
  .out_alpha_code  (out_alpha_code),
  .out_last        (out_last)
);

`default_nettype wire

[dv/tb_text_glyph_quad_layout.sv]
module tb_text_glyph_quad_layout
  import tgql_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int GLYPHS      = GLYPH_COUNT_DEF;
  // Nothing accepted on any channel for this long means the block is hung.
  // The longest legal quiet stretch is the receiver hold below.
  localparam int STALL_LIMIT = 4000;
  localparam int HOLD_AT     = 400;   // output words seen before the hold
  localparam int HOLD_CYCLES = 400;
  localparam int SETTLE      = 8;     // lets the fetch, generator and output stages clear

  // One vertex word as it leaves the block.
  typedef struct {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic [EDGE_W-1:0]         u;
    logic                      v;
    logic [COLOR_W-1:0]        color;
    logic [ALPHA_W-1:0]        alpha;
    logic                      last;
  } vertex_t;

  // Layout predictor plus the queue of vertices it expects.
  class quad_scoreboard;
    logic [WIDTH_W-1:0] width_mem [GLYPHS];
    logic [EDGE_W-1:0]  left_mem  [GLYPHS];
    logic [EDGE_W-1:0]  edge_sum;
    logic [COORD_W-1:0] pen_x;
    logic [COORD_W-1:0] line_y;
    logic [COLOR_W-1:0] color;
    logic [ALPHA_W-1:0] alpha;
    esc_t               esc;
    logic [7:0]         height;
    vertex_t            vert_q [$];
    int                 errors;

    function new();
      edge_sum = '0;
      height   = LINE_HEIGHT_RST;
      errors   = 0;
      clear_text();
    endfunction

    function void clear_text();
      pen_x  = '0;
      line_y = '0;
      color  = '0;
      alpha  = ALPHA_OPAQUE;
      esc    = ESC_NONE;
    endfunction

    function void set_height(logic [7:0] h);
      height = h;
    endfunction

    function int pending();
      return vert_q.size();
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 40) $display("%0t mismatch: %s", $time, msg);
    endtask

    function void push_vertex(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                              logic [EDGE_W-1:0] u, logic v, logic last);
      vertex_t vx;
      vx.x = x; vx.y = y; vx.u = u; vx.v = v;
      vx.color = color; vx.alpha = alpha; vx.last = last;
      vert_q.push_back(vx);
    endfunction

    function void note_word(logic act, logic [CHAR_W-1:0] ch, logic first,
                            logic [GIDX_W-1:0] gidx, logic [WIDTH_W-1:0] gw);
      logic [EDGE_W-1:0]  left, ul, ur;
      logic [COORD_W-1:0] x1, y1;
      logic [CHAR_W-1:0]  slot;
      logic [WIDTH_W-1:0] w;
      if (act) begin
        if (gidx < GLYPHS) begin
          left           = (gidx == 0) ? '0 : edge_sum;
          left_mem[gidx] = left;
          width_mem[gidx] = gw;
          edge_sum       = left + gw;
        end
        return;
      end
      if (first) clear_text();
      if (esc == ESC_ARG) begin
        esc = ESC_NONE;
        if (ch >= CHAR_0 && ch <= CHAR_9) color = COLOR_W'(ch - CHAR_0);
        else if (ch >= CHAR_LC_A && ch <= CHAR_LC_F)
          color = COLOR_W'(ch - CHAR_LC_A + HEX_A_VAL);
        else if (ch == CHAR_LC_T) esc = ESC_ALPHA;
        return;
      end
      if (esc == ESC_ALPHA) begin
        esc = ESC_NONE;
        if (ch >= CHAR_LC_A && ch <= CHAR_LC_Z) alpha = ALPHA_W'(ch - CHAR_LC_A);
        return;
      end
      if (ch == CHAR_NL) begin
        line_y = line_y - height;
        pen_x  = '0;
        return;
      end
      if (ch == CHAR_FF) begin
        esc = ESC_ARG;
        return;
      end
      if (ch < CHAR_SPACE || ch > CHAR_TILDE) return;
      slot = ch - CHAR_SPACE;
      if (slot >= GLYPHS) return;
      w  = width_mem[slot];
      ul = left_mem[slot];
      ur = ul + w;
      x1 = pen_x + w;
      y1 = line_y + height;
      // two triangles: bottom-left, top-right, top-left / bottom-left,
      // bottom-right, top-right
      push_vertex(pen_x, line_y, ul, 1'b1, 1'b0);
      push_vertex(x1,    y1,     ur, 1'b0, 1'b0);
      push_vertex(pen_x, y1,     ul, 1'b0, 1'b0);
      push_vertex(pen_x, line_y, ul, 1'b1, 1'b0);
      push_vertex(x1,    line_y, ur, 1'b1, 1'b0);
      push_vertex(x1,    y1,     ur, 1'b0, 1'b1);
      pen_x = x1;
    endfunction

    task check_vertex(vertex_t got);
      vertex_t want;
      if (vert_q.size() == 0) begin
        report($sformatf("unexpected vertex x=%0d y=%0d", got.x, got.y));
        return;
      end
      want = vert_q.pop_front();
      if (got.x !== want.x)
        report($sformatf("vert_x got %0d want %0d", got.x, want.x));
      if (got.y !== want.y)
        report($sformatf("vert_y got %0d want %0d", got.y, want.y));
      if (got.u !== want.u)
        report($sformatf("tex_u got %0d want %0d", got.u, want.u));
      if (got.v !== want.v)
        report($sformatf("tex_v got %0b want %0b", got.v, want.v));
      if (got.color !== want.color)
        report($sformatf("color_index got %0d want %0d", got.color, want.color));
      if (got.alpha !== want.alpha)
        report($sformatf("alpha_code got %0d want %0d", got.alpha, want.alpha));
      if (got.last !== want.last)
        report($sformatf("last got %0b want %0b", got.last, want.last));
    endtask
  endclass

  quad_scoreboard sb = new();

  // ---------------------------------------------------------------- DUT I/O
  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [7:0]            cfg_data  = 8'd0;

  logic                  in_valid         = 1'b0;
  logic                  in_ready;
  logic                  in_action        = 1'b0;
  logic [CHAR_W-1:0]     in_char_code     = '0;
  logic                  in_first_of_text = 1'b0;
  logic [GIDX_W-1:0]     in_glyph_index   = '0;
  logic [WIDTH_W-1:0]    in_glyph_width   = '0;

  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic signed [COORD_W-1:0] out_vert_x;
  logic signed [COORD_W-1:0] out_vert_y;
  logic [EDGE_W-1:0]     out_tex_u;
  logic                  out_tex_v;
  logic [COLOR_W-1:0]    out_color_index;
  logic [ALPHA_W-1:0]    out_alpha_code;
  logic                  out_last;

  // testbench control
  logic calm = 1'b0;           // no idling on either side while set
  int   out_words = 0;         // vertex words taken so far
  int   stall_cycles = 0;      // cycles since anything was accepted
  int   words_sent = 0;        // input words accepted, for phase lengths

  text_glyph_quad_layout i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_action        (in_action),
    .in_char_code     (in_char_code),
    .in_first_of_text (in_first_of_text),
    .in_glyph_index   (in_glyph_index),
    .in_glyph_width   (in_glyph_width),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_vert_x       (out_vert_x),
    .out_vert_y       (out_vert_y),
    .out_tex_u        (out_tex_u),
    .out_tex_v        (out_tex_v),
    .out_color_index  (out_color_index),
    .out_alpha_code   (out_alpha_code),
    .out_last         (out_last)
  );

  always #1 clk = ~clk;

  // ---------------------------------------------------------------- monitor
  // Everything is sampled at the rising edge, before this edge's updates land.
  // The output side is checked before the input side is noted so a stray
  // vertex cannot hide behind vertices queued at the same edge.
  always @(posedge clk) begin
    vertex_t seen;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) sb.set_height(cfg_data);
      if (out_valid && out_ready) begin
        seen.x     = out_vert_x;
        seen.y     = out_vert_y;
        seen.u     = out_tex_u;
        seen.v     = out_tex_v;
        seen.color = out_color_index;
        seen.alpha = out_alpha_code;
        seen.last  = out_last;
        sb.check_vertex(seen);
        out_words <= out_words + 1;
      end
      if (in_valid && in_ready) begin
        sb.note_word(in_action, in_char_code, in_first_of_text,
                     in_glyph_index, in_glyph_width);
        words_sent <= words_sent + 1;
      end
      if ((cfg_valid && cfg_ready) || (in_valid && in_ready) ||
          (out_valid && out_ready))
        stall_cycles <= 0;
      else
        stall_cycles <= stall_cycles + 1;
    end
  end

  // Hang detector.
  initial begin : watchdog
    while (stall_cycles < STALL_LIMIT) @(posedge clk);
    $display("tb_text_glyph_quad_layout: errors");
    $finish;
  end

  // ---------------------------------------------------------------- receiver
  // Random back-pressure, plus one long hold once enough vertices have gone
  // by, so the pipeline fills and in_ready drops while words keep coming.
  initial begin : receiver
    bit held;
    held = 1'b0;
    forever begin
      @(posedge clk);
      if (!held && out_words >= HOLD_AT) begin
        held = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        out_ready <= calm || ($urandom_range(0, 99) >= 25);
      end
    end
  end

  // ---------------------------------------------------------------- drivers
  // Offer one word and return at the edge that takes it. in_valid is left
  // high; the next call either drops it for a gap or replaces the payload.
  task automatic send_word(input logic act, input logic [CHAR_W-1:0] ch,
                           input logic first, input logic [GIDX_W-1:0] gidx,
                           input logic [WIDTH_W-1:0] gw);
    if (!calm) begin
      while ($urandom_range(0, 99) < 25) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid         <= 1'b1;
    in_action        <= act;
    in_char_code     <= ch;
    in_first_of_text <= first;
    in_glyph_index   <= gidx;
    in_glyph_width   <= gw;
    do @(posedge clk); while (!in_ready);
  endtask

  // Text word; the load-only fields carry noise.
  task automatic send_char(input logic [CHAR_W-1:0] ch, input logic first);
    send_word(1'b0, ch, first, GIDX_W'($urandom), WIDTH_W'($urandom));
  endtask

  // Load word; the text-only fields carry noise.
  task automatic send_load(input logic [GIDX_W-1:0] idx, input logic [WIDTH_W-1:0] w);
    send_word(1'b1, CHAR_W'($urandom), 1'($urandom), idx, w);
  endtask

  // Drain: no vertex outstanding (checked off the edge), then let any load or
  // dropped word still in the pipe clear out.
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(negedge clk); while (sb.pending() != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_line_height(input logic [7:0] h);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_data  <= h;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // Full font in index order. full_width: every glyph 255 wide.
  // Otherwise random widths, with 'A' zero wide and '~' at the maximum.
  task automatic load_font(input bit full_width);
    logic [WIDTH_W-1:0] w;
    for (int i = 0; i < GLYPHS; i++) begin
      if (full_width)   w = '1;
      else if (i == 33) w = '0;
      else if (i == 94) w = '1;
      else              w = WIDTH_W'($urandom);
      send_load(GIDX_W'(i), w);
    end
  endtask

  task automatic send_hex_escape();
    int d;
    d = $urandom_range(0, 15);
    send_char(CHAR_FF, 1'b0);
    send_char((d < 10) ? CHAR_0 + CHAR_W'(d) : CHAR_LC_A + CHAR_W'(d - 10), 1'b0);
  endtask

  // One random token of a text: mostly glyphs and well-formed escapes,
  // some broken escapes, dropped bytes and interleaved loads.
  task automatic send_token();
    int  r;
    logic f;
    r = $urandom_range(0, 99);
    f = ($urandom_range(0, 99) < 3);
    if (r < 55) begin
      send_char(CHAR_W'($urandom_range(CHAR_SPACE, CHAR_TILDE)), f);
    end else if (r < 63) begin
      send_char(CHAR_NL, f);
    end else if (r < 71) begin
      send_hex_escape();
    end else if (r < 78) begin
      send_char(CHAR_FF, f);
      send_char(CHAR_LC_T, 1'b0);
      send_char(CHAR_W'($urandom_range(CHAR_LC_A, CHAR_LC_Z)), 1'b0);
    end else if (r < 82) begin
      send_char(CHAR_FF, f);
      send_char(CHAR_LC_T, 1'b0);
      send_char(CHAR_W'($urandom), 1'b0);
    end else if (r < 87) begin
      send_char(CHAR_FF, f);
      send_char(CHAR_W'($urandom), 1'b0);
    end else if (r < 90) begin
      send_char(CHAR_FF, f);      // may stay open into the next text
    end else if (r < 94) begin
      if ($urandom_range(0, 1))
        send_char(CHAR_W'($urandom_range(0, 31)), f);
      else
        send_char(CHAR_W'($urandom_range(127, 255)), f);
    end else begin
      send_load(GIDX_W'($urandom), WIDTH_W'($urandom));
    end
  endtask

  // Random texts until n more input words have gone in.
  task automatic random_texts(input int n);
    int stop;
    int len;
    stop = words_sent + n;
    while (words_sent < stop) begin
      len = $urandom_range(1, 30);
      send_char(CHAR_W'($urandom_range(CHAR_SPACE, CHAR_TILDE)), 1'b1);
      for (int k = 0; k < len && words_sent < stop; k++) send_token();
    end
  endtask

  // ---------------------------------------------------------------- main
  initial begin : main
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // tallest glyphs first
    write_line_height(8'd255);
    load_font(1'b0);
    send_load(GIDX_W'(GLYPHS), 8'd17);   // past the table: ignored
    send_load('1, 8'd99);

    // directed text
    send_char(CHAR_SPACE, 1'b1);         // slot 0, left edge 0
    send_char(CHAR_TILDE, 1'b0);         // widest glyph, last slot
    send_char(CHAR_NL, 1'b0);            // line wraps below zero
    send_char("A", 1'b0);                // zero-width glyph
    send_char(CHAR_FF, 1'b0);
    send_char(CHAR_9, 1'b0);
    send_char("B", 1'b0);
    send_char(CHAR_FF, 1'b0);
    send_char(CHAR_LC_F, 1'b0);
    send_char(CHAR_FF, 1'b0);
    send_char(CHAR_LC_T, 1'b0);
    send_char(CHAR_LC_A, 1'b0);          // alpha 0
    send_char("C", 1'b0);
    send_char(CHAR_FF, 1'b0);
    send_char(CHAR_LC_T, 1'b0);
    send_char(CHAR_LC_Z, 1'b0);          // back to opaque
    send_char(CHAR_FF, 1'b0);
    send_char(CHAR_LC_T, 1'b0);
    send_char("5", 1'b0);                // bad alpha letter, still eaten
    send_char(CHAR_FF, 1'b0);
    send_char("g", 1'b0);                // not hex: escape just ends
    send_char(CHAR_FF, 1'b0);
    send_char(CHAR_NL, 1'b0);            // newline eaten as escape arg
    send_char("D", 1'b0);
    send_char(8'h00, 1'b0);              // dropped bytes
    send_char(8'h1F, 1'b0);
    send_char(8'h7F, 1'b0);
    send_char(8'hFF, 1'b0);
    send_char(CHAR_FF, 1'b0);            // open escape ...
    send_char("E", 1'b1);                // ... cleared by new text

    write_line_height(8'd0);
    random_texts(25);

    write_line_height(8'($urandom));
    calm <= 1'b1;                        // stretch with no idling
    random_texts(25);
    calm <= 1'b0;

    write_line_height(8'd1);
    random_texts(25);

    // Space widened to the maximum, then one long line of spaces with no
    // idling, so the pen wraps past 16 bits.
    write_line_height(8'($urandom));
    send_load(GIDX_W'(0), '1);
    calm <= 1'b1;
    send_char(CHAR_SPACE, 1'b1);
    for (int k = 0; k < 260; k++) begin
      if ($urandom_range(0, 99) < 3) send_hex_escape();
      send_char(CHAR_SPACE, 1'b0);
    end
    calm <= 1'b0;

    write_line_height(LINE_HEIGHT_RST);
    random_texts(10);

    wait_drained();
    repeat (SETTLE) @(posedge clk);
    if (sb.pending() != 0) sb.report($sformatf("%0d vertices never came", sb.pending()));
    if (sb.errors == 0) begin
      $display("tb_text_glyph_quad_layout: clean");
    end else begin
      $display("tb_text_glyph_quad_layout: errors");
    end
    $finish;
  end

endmodule
